/* hdl/trsi_pkg.sv */
// Shared types and constants for the text row start indexer.
// No dependencies; used by every module in hdl/.
package trsi_pkg;

  localparam int unsigned OfsW         = 40;
  localparam int unsigned RowW         = 32;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned CommentSlots = 4;
  localparam int unsigned CharsW       = 32;
  localparam int unsigned ActiveSlots  = (CommentSlots < CharsW / ByteW) ?
                                         CommentSlots : CharsW / ByteW;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 40;
  localparam int unsigned OutDataW     = RowW + OfsW;
  localparam int unsigned FifoDepth    = 4;
  localparam int unsigned FifoAw       = 2;
  localparam int unsigned FifoCntW     = 3;

  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChLf    = 8'h0A;

  typedef enum logic [CfgIdxW-1:0] {
    RegCommentChars = 3'd0,
    RegCommentCount = 3'd1,
    RegBreakChar    = 3'd2,
    RegBreakSize    = 3'd3,
    RegFixedColumns = 3'd4,
    RegMinRowSpan   = 3'd5,
    RegStartOffset  = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    KindRow      = 1'b0,
    KindChunkEnd = 1'b1
  } kind_e;

  typedef struct packed {
    logic [CharsW-1:0] comment_chars;
    logic [2:0]        comment_count;
    logic [ByteW-1:0]  break_char;
    logic [1:0]        break_size;
    logic              fixed_columns;
    logic [RowW-1:0]   min_row_span;
  } cfg_t;

  typedef struct packed {
    logic            valid;
    logic [OfsW-1:0] offset;
  } start_load_t;

  typedef struct packed {
    kind_e           kind;
    logic [RowW-1:0] row_number;
    logic [OfsW-1:0] next_start;
    logic            last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_out_t;

endpackage

/* hdl/trsi_cfg.sv */
// Configuration register bank of the text row start indexer.
// Depends on trsi_pkg; a start offset write also raises a load to the scanner.
module trsi_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [trsi_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [trsi_pkg::CfgDataW-1:0] cfg_data_i,
  output trsi_pkg::cfg_t                cfg_o,
  output trsi_pkg::start_load_t         load_o
);

  trsi_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    load_o.valid  = 1'b0;
    load_o.offset = cfg_data_i[trsi_pkg::OfsW-1:0];
    if (cfg_valid_i) begin
      unique case (trsi_pkg::cfg_reg_e'(cfg_index_i))
        trsi_pkg::RegCommentChars: cfg_d.comment_chars = cfg_data_i[31:0];
        trsi_pkg::RegCommentCount: cfg_d.comment_count = cfg_data_i[2:0];
        trsi_pkg::RegBreakChar:    cfg_d.break_char    = cfg_data_i[7:0];
        trsi_pkg::RegBreakSize:    cfg_d.break_size    = cfg_data_i[1:0];
        trsi_pkg::RegFixedColumns: cfg_d.fixed_columns = cfg_data_i[0];
        trsi_pkg::RegMinRowSpan:   cfg_d.min_row_span  = cfg_data_i[31:0];
        trsi_pkg::RegStartOffset:  load_o.valid        = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.comment_chars <= '0;
      cfg_q.comment_count <= '0;
      cfg_q.break_char    <= trsi_pkg::ChLf;
      cfg_q.break_size    <= 2'd1;
      cfg_q.fixed_columns <= 1'b0;
      cfg_q.min_row_span  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/trsi_scan.sv */
// Byte classifier and row tracking state of the text row start indexer.
// Depends on trsi_pkg; produces up to two results per accepted byte.
module trsi_scan (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [trsi_pkg::ByteW-1:0] text_byte_i,
  input  logic                       chunk_end_i,
  input  trsi_pkg::cfg_t             cfg_i,
  input  trsi_pkg::start_load_t      load_i,
  output trsi_pkg::step_out_t        step_o
);

  logic [trsi_pkg::OfsW-1:0] pos_q, pos_d, pend_q, pend_d, prev_q, prev_d;
  logic [trsi_pkg::OfsW-1:0] nxt, limit;
  logic [trsi_pkg::RowW-1:0] rows_q, rows_d;
  logic has_data_q, has_data_d, in_comment_q, in_comment_d, halted_q, halted_d;
  logic comment_hit, blank, recorded;
  trsi_pkg::result_t row_res, end_res;

  always_comb begin
    comment_hit = 1'b0;
    for (int k = 0; k < int'(trsi_pkg::ActiveSlots); k++) begin
      if (k < int'(cfg_i.comment_count) &&
          cfg_i.comment_chars[8*k +: 8] == text_byte_i) begin
        comment_hit = 1'b1;
      end
    end
  end

  assign blank = (text_byte_i == trsi_pkg::ChSpace) || (text_byte_i == trsi_pkg::ChTab) ||
                 (text_byte_i == trsi_pkg::ChCr) || (text_byte_i == trsi_pkg::ChLf);

  assign nxt   = pos_q + trsi_pkg::OfsW'(cfg_i.break_size);
  assign limit = prev_q + trsi_pkg::OfsW'(cfg_i.min_row_span);

  always_comb begin
    pend_d       = pend_q;
    prev_d       = prev_q;
    rows_d       = rows_q;
    has_data_d   = has_data_q;
    in_comment_d = in_comment_q;
    halted_d     = halted_q;
    recorded     = 1'b0;
    priority if (comment_hit) begin
      in_comment_d = 1'b1;
    end else if (text_byte_i == cfg_i.break_char) begin
      if (has_data_q) begin
        if (!halted_q) begin
          if (cfg_i.fixed_columns && nxt <= limit) begin
            halted_d = 1'b1;
            pend_d   = prev_q;
          end else begin
            rows_d   = rows_q + 1'b1;
            pend_d   = nxt;
            prev_d   = nxt;
            recorded = 1'b1;
          end
        end
      end else if (in_comment_q && !halted_q) begin
        pend_d = nxt;
      end
      has_data_d   = 1'b0;
      in_comment_d = 1'b0;
    end else if (!has_data_q && !in_comment_q && !blank) begin
      has_data_d = 1'b1;
    end
    if (chunk_end_i) begin
      prev_d       = pend_d;
      has_data_d   = 1'b0;
      in_comment_d = 1'b0;
    end
    pos_d = pos_q + 1'b1;
  end

  always_comb begin
    row_res.kind       = trsi_pkg::KindRow;
    row_res.row_number = rows_d;
    row_res.next_start = nxt;
    row_res.last       = !chunk_end_i;
    end_res.kind       = trsi_pkg::KindChunkEnd;
    end_res.row_number = rows_d;
    end_res.next_start = pend_d;
    end_res.last       = 1'b1;
    step_o.first  = recorded ? row_res : end_res;
    step_o.second = end_res;
    step_o.count  = 2'(recorded) + 2'(chunk_end_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      pend_q       <= '0;
      prev_q       <= '0;
      rows_q       <= '0;
      has_data_q   <= 1'b0;
      in_comment_q <= 1'b0;
      halted_q     <= 1'b0;
    end else if (load_i.valid) begin
      pos_q        <= load_i.offset;
      pend_q       <= load_i.offset;
      prev_q       <= load_i.offset;
      has_data_q   <= 1'b0;
      in_comment_q <= 1'b0;
    end else if (accept_i) begin
      pos_q        <= pos_d;
      pend_q       <= pend_d;
      prev_q       <= prev_d;
      rows_q       <= rows_d;
      has_data_q   <= has_data_d;
      in_comment_q <= in_comment_d;
      halted_q     <= halted_d;
    end
  end

endmodule

/* hdl/trsi_fifo.sv */
// Result queue of the text row start indexer: two words in, one word out.
// Depends on trsi_pkg; input ready needs room for two words.
module trsi_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  trsi_pkg::step_out_t step_i,
  output logic                room_o,
  output logic                valid_o,
  input  logic                ready_i,
  output trsi_pkg::result_t   word_o
);

  trsi_pkg::result_t mem_q [trsi_pkg::FifoDepth];
  logic [trsi_pkg::FifoAw-1:0]   head_q, tail_q, tail_nxt;
  logic [trsi_pkg::FifoCntW-1:0] cnt_q, push_n;
  logic pop;

  assign pop      = valid_o && ready_i;
  assign push_n   = push_i ? trsi_pkg::FifoCntW'(step_i.count) : '0;
  assign tail_nxt = tail_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (push_i && step_i.count != 2'd0) mem_q[tail_q] <= step_i.first;
    if (push_i && step_i.count == 2'd2) mem_q[tail_nxt] <= step_i.second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      tail_q <= tail_q + trsi_pkg::FifoAw'(push_n);
      if (pop) head_q <= head_q + 1'b1;
      cnt_q <= cnt_q + push_n - trsi_pkg::FifoCntW'(pop);
    end
  end

  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= trsi_pkg::FifoCntW'(trsi_pkg::FifoDepth - 2));
  assign word_o  = mem_q[head_q];

endmodule

/* hdl/text_row_start_indexer.sv */
// Text row start indexer: finds the file offsets where data rows begin.
// Bytes enter on the s_axis channel, tlast marking the last byte of a chunk.
// Each byte is classified in the cycle it is accepted; a line break after data
// yields a row word unless the fixed-column check halts the scan, and the last
// byte of a chunk yields a pending start word. Words leave on m_axis: tuser is
// the kind (0 row, 1 chunk end), tlast marks the final word caused by a byte.
// A byte's words are registered into a four word queue and leave on m_axis one
// word per cycle while m_axis_tready is high. s_axis_tready stays high while
// the queue has room for two words, so the rate is one byte a cycle, bounded by
// the single output word per cycle when a byte gives two words.
// The user must write registers on the cfg channel (always ready) only while
// the block is idle; the block does not enforce this. Writing the start offset
// reloads position and row starts. Reset clears the queue, the row count and
// the halt flag, sets line break to LF with size one, and all offsets to zero.
// A stall on m_axis fills the queue and then drops s_axis_tready; no word is
// lost.
// Depends on trsi_pkg, trsi_cfg, trsi_scan and trsi_fifo.
module text_row_start_indexer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [trsi_pkg::ByteW-1:0]      s_axis_tdata_i,  // text_byte
  input  logic                            s_axis_tlast_i,  // chunk_end
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [trsi_pkg::OutDataW-1:0]   m_axis_tdata_o,  // row_number, next_start
  output logic                            m_axis_tuser_o,  // kind
  output logic                            m_axis_tlast_o,  // last_of_run
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [trsi_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [trsi_pkg::CfgDataW-1:0]   cfg_data_i
);

  trsi_pkg::cfg_t        cfg;
  trsi_pkg::start_load_t load;
  trsi_pkg::step_out_t   step;
  trsi_pkg::result_t     word;
  logic room, accept;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = room;
  assign accept          = s_axis_tvalid_i && room;

  trsi_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .load_o      (load)
  );

  trsi_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .text_byte_i (s_axis_tdata_i),
    .chunk_end_i (s_axis_tlast_i),
    .cfg_i       (cfg),
    .load_i      (load),
    .step_o      (step)
  );

  trsi_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .step_i  (step),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .word_o  (word)
  );

  assign m_axis_tdata_o = {word.next_start, word.row_number};
  assign m_axis_tuser_o = word.kind;
  assign m_axis_tlast_o = word.last;

endmodule
